/* src/assert_macros.svh */
// Assertion macros used by the port-level checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define ASSERT_NOW(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");

// Check that a condition in this cycle implies another one in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* src/acs_pkg.sv */
// Package with types, codes and the reset table of the sensor register file.
`default_nettype none

package acs_pkg;

  localparam int MapBytesDefault = 128;
  localparam int FirstWritableDefault = 10;

  typedef enum logic [1:0] {
    OP_CS   = 2'd0,
    OP_TX   = 2'd1,
    OP_RX   = 2'd2,
    OP_AXIS = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RECV,
    ST_CLR,
    ST_AX_LO,
    ST_AX_HI
  } state_t;

  typedef struct packed {
    logic       re;
    logic [7:0] raddr;
    logic       we;
    logic [7:0] waddr;
    logic [7:0] wdata;
  } mem_req_t;

  function automatic logic [7:0] reset_value(input logic [7:0] a);
    logic [7:0] v;
    unique case (a)
      8'h00: v = 8'h02;
      8'h0B: v = 8'h03;
      8'h0C: v = 8'd20;
      8'h0D: v = 8'd150;
      8'h0E: v = 8'd160;
      8'h0F: v = 8'd150;
      8'h12: v = 8'd162;
      8'h13: v = 8'd13;
      8'h14: v = 8'h0E;
      8'h15: v = 8'h80;
      8'h2B: v = 8'h03;
      8'h2C: v = 8'd20;
      8'h2D: v = 8'd150;
      8'h2E: v = 8'd160;
      8'h2F: v = 8'd150;
      8'h32: v = 8'd162;
      8'h33: v = 8'd13;
      8'h34: v = 8'h0E;
      8'h35: v = 8'h80;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

/* src/acs_regmem.sv */
// Register map memory: one read and one write port, reset defaults via valid bits.
`default_nettype none

module acs_regmem #(
  parameter int MAP_BYTES = acs_pkg::MapBytesDefault
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire acs_pkg::mem_req_t req,
  output logic [7:0]             rd_data
);

  localparam int AW = $clog2(MAP_BYTES);

  logic [7:0]           mem [MAP_BYTES];
  logic [MAP_BYTES-1:0] written;
  logic [7:0]           mem_q;
  logic [7:0]           init_q;
  logic                 hit_q;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr[AW-1:0]] <= req.wdata;
    end
    if (req.re) begin
      mem_q  <= mem[req.raddr[AW-1:0]];
      init_q <= acs_pkg::reset_value(req.raddr);
      hit_q  <= written[req.raddr[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (req.we) begin
      written[req.waddr[AW-1:0]] <= 1'b1;
    end
  end

  assign rd_data = hit_q ? mem_q : init_q;

endmodule

`default_nettype wire

/* src/accel_sensor_spi_register_file.sv */
// Top level of the SPI slave register file of a three-axis acceleration sensor.
// Each request on the s_ side is one bus event: a chip select change, a byte from
// the host (echoed on m_), a receive (answered from the register map in read mode)
// or a new set of axis samples. Requests are taken one at a time while the block
// is idle and its output slot is free or draining. A receive that returns a byte
// reads the register map first and then, for an axis register, clears its new
// flag; an axis update runs three read-modify-writes, which share the single
// read and single write port of the register map memory. The reset defaults
// are served by per-entry valid bits, so no clearing pass follows reset.
`default_nettype none

module accel_sensor_spi_register_file #(
  parameter int MAP_BYTES      = acs_pkg::MapBytesDefault,
  parameter int FIRST_WRITABLE = acs_pkg::FirstWritableDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // cs_level[0], tx_byte[8:1], sample_x[18:9], sample_y[28:19], sample_z[38:29]
  input  wire logic [39:0] s_tdata,
  // opcode[1:0]
  input  wire logic [1:0]  s_tuser,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // rx_byte[7:0]
  output logic [7:0]       m_tdata
);

  localparam int ModSteps = 127 / MAP_BYTES;

  function automatic logic [7:0] map_index(input logic [7:0] a);
    logic [8:0] v;
    v = {1'b0, a};
    for (int i = 0; i < ModSteps; i++) begin
      if (v >= 9'(MAP_BYTES)) begin
        v = v - 9'(MAP_BYTES);
      end
    end
    return v[7:0];
  endfunction

  acs_pkg::state_t   state, state_next;
  acs_pkg::mem_req_t req;
  acs_pkg::op_t      op;

  logic [7:0]  command, command_next;
  logic [7:0]  byte_count, byte_count_next;
  logic        selected, selected_next;
  logic        out_valid, out_valid_next;
  logic [7:0]  out_data, out_data_next;
  logic [6:0]  rx_addr;
  logic [1:0]  axis;
  logic [9:0]  sample [3];
  logic [7:0]  rd_data;

  logic        accept;
  logic        cs_level;
  logic [7:0]  tx_byte;
  logic        reading;
  logic [6:0]  cmd_addr;
  logic        rx_ok;
  logic [7:0]  rx_sum;
  logic        flag_hit;
  logic [7:0]  bc_start;
  logic [9:0]  cur_sample;

  assign op       = acs_pkg::op_t'(s_tuser);
  assign cs_level = s_tdata[0];
  assign tx_byte  = s_tdata[8:1];
  assign reading  = command[7];
  assign cmd_addr = command[6:0];
  assign accept   = s_tvalid && s_tready;
  assign s_tready = (state == acs_pkg::ST_IDLE) && (!out_valid || m_tready);
  assign rx_ok    = selected && reading && (byte_count > 8'd1);
  assign rx_sum   = {1'b0, cmd_addr} + byte_count - 8'd2;
  assign flag_hit = (rx_addr >= 7'd2) && (rx_addr <= 7'd7);
  assign bc_start = (reading && !tx_byte[7]) ? 8'd0 : byte_count;
  assign cur_sample = sample[axis];

  always_comb begin
    state_next = state;
    unique case (state)
      acs_pkg::ST_IDLE: begin
        if (accept && op == acs_pkg::OP_RX && rx_ok) begin
          state_next = acs_pkg::ST_RECV;
        end else if (accept && op == acs_pkg::OP_AXIS) begin
          state_next = acs_pkg::ST_AX_LO;
        end
      end
      acs_pkg::ST_RECV:  state_next = flag_hit ? acs_pkg::ST_CLR : acs_pkg::ST_IDLE;
      acs_pkg::ST_CLR:   state_next = acs_pkg::ST_IDLE;
      acs_pkg::ST_AX_LO: state_next = acs_pkg::ST_AX_HI;
      acs_pkg::ST_AX_HI: state_next = (axis == 2'd2) ? acs_pkg::ST_IDLE : acs_pkg::ST_AX_LO;
      default:           state_next = acs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    req             = '0;
    command_next    = command;
    byte_count_next = byte_count;
    selected_next   = selected;
    out_valid_next  = out_valid && !m_tready;
    out_data_next   = out_data;
    unique case (state)
      acs_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (op)
            acs_pkg::OP_CS: begin
              selected_next = !cs_level;
              if (cs_level) begin
                byte_count_next = 8'd0;
              end
            end
            acs_pkg::OP_TX: begin
              if (selected) begin
                byte_count_next = bc_start + 8'd1;
                if (bc_start == 8'd0) begin
                  command_next = tx_byte;
                end else if (!reading) begin
                  req.we          = (cmd_addr >= 7'(FIRST_WRITABLE));
                  req.waddr       = map_index({1'b0, cmd_addr});
                  req.wdata       = tx_byte;
                  byte_count_next = 8'd1;
                end
                out_valid_next = 1'b1;
                out_data_next  = tx_byte;
              end
            end
            acs_pkg::OP_RX: begin
              req.re    = rx_ok;
              req.raddr = map_index({1'b0, rx_sum[6:0]});
            end
            acs_pkg::OP_AXIS: begin
            end
            default: begin
            end
          endcase
        end
      end
      acs_pkg::ST_RECV: begin
        out_valid_next = 1'b1;
        out_data_next  = rd_data;
        req.re         = flag_hit;
        req.raddr      = {1'b0, rx_addr[6:1], 1'b1};
      end
      acs_pkg::ST_CLR: begin
        req.we    = 1'b1;
        req.waddr = {1'b0, rx_addr[6:1], 1'b1};
        req.wdata = rd_data & 8'h7F;
      end
      acs_pkg::ST_AX_LO: begin
        req.re    = 1'b1;
        req.raddr = {4'd0, 1'b0, axis, 1'b1} + 8'd2;
        req.we    = 1'b1;
        req.waddr = {4'd0, 1'b0, axis, 1'b0} + 8'd2;
        req.wdata = cur_sample[7:0];
      end
      acs_pkg::ST_AX_HI: begin
        req.we    = 1'b1;
        req.waddr = {4'd0, 1'b0, axis, 1'b1} + 8'd2;
        req.wdata = (rd_data & 8'h7C) | 8'h80 | {6'd0, cur_sample[9:8]};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= acs_pkg::ST_IDLE;
      command    <= 8'd0;
      byte_count <= 8'd0;
      selected   <= 1'b0;
      out_valid  <= 1'b0;
      axis       <= 2'd0;
    end else begin
      state      <= state_next;
      command    <= command_next;
      byte_count <= byte_count_next;
      selected   <= selected_next;
      out_valid  <= out_valid_next;
      if (state == acs_pkg::ST_IDLE) begin
        axis <= 2'd0;
      end else if (state == acs_pkg::ST_AX_HI) begin
        axis <= axis + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data <= out_data_next;
    if (accept && op == acs_pkg::OP_RX) begin
      rx_addr <= rx_sum[6:0];
    end
    if (accept && op == acs_pkg::OP_AXIS) begin
      sample[0] <= s_tdata[18:9];
      sample[1] <= s_tdata[28:19];
      sample[2] <= s_tdata[38:29];
    end
  end

  acs_regmem #(
    .MAP_BYTES(MAP_BYTES)
  ) u_regmem (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .rd_data (rd_data)
  );

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

endmodule

`default_nettype wire

/* src/acs_checker.sv */
// Port-level checker of the sensor register file, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module acs_port_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic [39:0] s_tdata,
  input wire logic [1:0]  s_tuser,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [7:0]  m_tdata
);

  logic s_take;
  logic tx_take;
  logic rx_take;
  logic ax_take;

  assign s_take  = s_tvalid && s_tready;
  assign tx_take = s_take && (s_tuser == acs_pkg::OP_TX);
  assign rx_take = s_take && (s_tuser == acs_pkg::OP_RX);
  assign ax_take = s_take && (s_tuser == acs_pkg::OP_AXIS);

  `ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
  `ASSERT_NEXT(a_axis_busy, clk, rst, ax_take, !s_tready)
  `ASSERT_NEXT(a_tx_echo, clk, rst, tx_take && (m_tvalid == 1'b0 || m_tready), !m_tvalid || m_tdata == $past(s_tdata[8:1]))
  `ASSERT_NOW(a_result_source, clk, rst, !$rose(m_tvalid) || $past(tx_take) || $past(rx_take, 2))
  `ASSERT_NEXT(a_reset_empty, clk, 1'b0, rst, !m_tvalid)

endmodule

bind accel_sensor_spi_register_file acs_port_checker u_acs_checker (.*);

`default_nettype wire

/* tb/acs_checker.sv */
// Checker: tracks the register map, predicts each returned byte and compares it.
module acs_checker
  import acs_pkg::*;
#(
  parameter int MAP_BYTES      = MapBytesDefault,
  parameter int FIRST_WRITABLE = FirstWritableDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  // cs_level[0], tx_byte[8:1], sample_x[18:9], sample_y[28:19], sample_z[38:29]
  input  logic [39:0] s_tdata,
  // opcode[1:0]
  input  logic [1:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  // rx_byte[7:0]
  input  logic [7:0]  m_tdata,
  output int          fails,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [6:0] AXIS_FIRST_REG = 7'h02;
  localparam logic [6:0] AXIS_LAST_REG  = 7'h07;
  localparam int         REPORT_LIMIT   = 10;

  logic [7:0] reg_map [MAP_BYTES];
  logic [7:0] command;
  logic [7:0] byte_count;
  logic       selected;
  logic [7:0] expected_rx [$];
  logic [7:0] want;
  int         fail_total;

  function automatic logic [7:0] power_on_byte(int a);
    logic [7:0] v;
    case (a)
      'h00:        v = 8'h02;
      'h0B, 'h2B:  v = 8'h03;
      'h0C, 'h2C:  v = 8'd20;
      'h0D, 'h2D:  v = 8'd150;
      'h0E, 'h2E:  v = 8'd160;
      'h0F, 'h2F:  v = 8'd150;
      'h12, 'h32:  v = 8'd162;
      'h13, 'h33:  v = 8'd13;
      'h14, 'h34:  v = 8'h0E;
      'h15, 'h35:  v = 8'h80;
      default:     v = 8'h00;
    endcase
    return v;
  endfunction

  function automatic void predict_request(op_t op, logic [39:0] d);
    logic       reading;
    logic [6:0] addr;
    logic [7:0] tx;
    logic [7:0] sum;
    logic [6:0] a;
    logic [9:0] sample;
    int         lo;
    int         hi;
    reading = command[7];
    addr    = command[6:0];
    tx      = d[8:1];
    case (op)
      OP_CS: begin
        selected = ~d[0];
        if (!selected) byte_count = 8'd0;
      end
      OP_TX: begin
        if (selected) begin
          if (reading && !tx[7]) byte_count = 8'd0;
          if (byte_count == 8'd0) begin
            command = tx;
          end else if (!reading) begin
            if (int'(addr) >= FIRST_WRITABLE) reg_map[int'(addr) % MAP_BYTES] = tx;
            byte_count = 8'd0;
          end
          byte_count = byte_count + 8'd1;
          expected_rx.push_back(tx);
        end
      end
      OP_RX: begin
        if (selected && reading && byte_count > 8'd1) begin
          sum = {1'b0, addr} + byte_count - 8'd2;
          a   = sum[6:0];
          expected_rx.push_back(reg_map[int'(a) % MAP_BYTES]);
          if (a >= AXIS_FIRST_REG && a <= AXIS_LAST_REG) begin
            hi = int'({a[6:1], 1'b1}) % MAP_BYTES;
            reg_map[hi][7] = 1'b0;
          end
        end
      end
      OP_AXIS: begin
        for (int ax = 0; ax < 3; ax++) begin
          sample = d[9 + 10 * ax +: 10];
          lo = (2 * ax + 2) % MAP_BYTES;
          hi = (2 * ax + 3) % MAP_BYTES;
          reg_map[lo] = sample[7:0];
          reg_map[hi] = (reg_map[hi] & 8'h7C) | 8'h80 | {6'd0, sample[9:8]};
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void note_failure(string what, logic [7:0] exp_byte, logic [7:0] got);
    if (fail_total < REPORT_LIMIT)
      $display("%0t: %s rx_byte expected %02h got %02h", $realtime, what, exp_byte, got);
    fail_total++;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAP_BYTES; i++) reg_map[i] = power_on_byte(i);
      command    = 8'd0;
      byte_count = 8'd0;
      selected   = 1'b0;
      expected_rx.delete();
      fail_total = 0;
    end else begin
      if (s_tvalid && s_tready) predict_request(op_t'(s_tuser), s_tdata);
      if (m_tvalid && m_tready) begin
        if (expected_rx.size() == 0) begin
          note_failure("unexpected result:", 8'hxx, m_tdata);
        end else begin
          want = expected_rx.pop_front();
          if (want !== m_tdata) note_failure("mismatch:", want, m_tdata);
        end
      end
    end
    fails   <= fail_total;
    pending <= expected_rx.size();
  end

endmodule

/* tb/tb_top.sv */
// Top of the testbench: clock, reset, bus stimulus and final verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import acs_pkg::*;

  localparam int STALL_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 20;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata  = '0;
  logic [1:0]  s_tuser  = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;
  int          fails;
  int          pending;
  int          idle_cycles = 0;
  int          req_count = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;

  accel_sensor_spi_register_file u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  acs_checker u_checker (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .fails    (fails),
    .pending  (pending)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic send_req(op_t op, logic cs, logic [7:0] tx,
                          logic [9:0] sx, logic [9:0] sy, logic [9:0] sz);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {1'b0, sz, sy, sx, tx, cs};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    req_count++;
  endtask

  task automatic cs_change(logic level);
    send_req(OP_CS, level, 8'($urandom), 10'($urandom), 10'($urandom), 10'($urandom));
  endtask

  task automatic tx_send(logic [7:0] b);
    send_req(OP_TX, 1'($urandom), b, 10'($urandom), 10'($urandom), 10'($urandom));
  endtask

  task automatic rx_req();
    send_req(OP_RX, 1'($urandom), 8'($urandom), 10'($urandom), 10'($urandom),
             10'($urandom));
  endtask

  task automatic axis_update(logic [9:0] sx, logic [9:0] sy, logic [9:0] sz);
    send_req(OP_AXIS, 1'($urandom), 8'($urandom), sx, sy, sz);
  endtask

  // bias toward the axis registers and both ends of the map
  function automatic logic [6:0] pick_addr();
    int r;
    r = $urandom_range(5);
    case (r)
      0, 1:    return 7'($urandom_range(7));
      2:       return 7'($urandom_range(15, 8));
      3:       return 7'($urandom_range(127, 120));
      default: return 7'($urandom);
    endcase
  endfunction

  task automatic random_sequence();
    int kind;
    int n;
    kind = $urandom_range(99);
    if (kind < 35) begin
      cs_change(1'b1);
      cs_change(1'b0);
      tx_send({1'b1, pick_addr()});
      n = $urandom_range(6, 1);
      for (int k = 0; k < n; k++) begin
        tx_send({1'b1, 7'($urandom)});
        repeat ($urandom_range(2, 1)) rx_req();
      end
      if ($urandom_range(1)) cs_change(1'b1);
    end else if (kind < 60) begin
      cs_change(1'b1);
      cs_change(1'b0);
      tx_send({1'b0, pick_addr()});
      n = $urandom_range(4, 1);
      for (int k = 0; k < n; k++) tx_send(8'($urandom));
      if ($urandom_range(1)) cs_change(1'b1);
    end else if (kind < 75) begin
      axis_update(10'($urandom), 10'($urandom), 10'($urandom));
    end else begin
      send_req(op_t'(2'($urandom_range(3))), 1'($urandom), 8'($urandom),
               10'($urandom), 10'($urandom), 10'($urandom));
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // idle bus, deselected device, then the axis and read/write paths
    rx_req();
    tx_send(8'h8A);
    axis_update(10'h3FF, 10'h000, 10'h2AA);
    cs_change(1'b0);
    tx_send(8'h82);
    rx_req();
    tx_send(8'hFF);
    rx_req();
    tx_send(8'h80);
    rx_req();
    rx_req();
    tx_send(8'h0A);
    tx_send(8'h5A);
    tx_send(8'hA5);
    cs_change(1'b1);
    cs_change(1'b0);
    tx_send(8'h09);
    tx_send(8'h77);
    rx_req();
    cs_change(1'b1);
    cs_change(1'b0);
    tx_send(8'hFF);
    tx_send(8'h80);
    rx_req();
    tx_send(8'h80);
    rx_req();

    while (req_count < 200) random_sequence();

    send_idle_pct = 82;
    while (req_count < 330) random_sequence();

    send_idle_pct  = 0;
    recv_stall_pct = 82;
    while (req_count < 460) random_sequence();

    send_idle_pct  = 7;
    recv_stall_pct = 7;
    // long read burst: walk the whole map and wrap the byte count
    cs_change(1'b1);
    cs_change(1'b0);
    tx_send({1'b1, 7'($urandom)});
    for (int k = 0; k < 262; k++) begin
      tx_send({1'b1, 7'($urandom)});
      if ($urandom_range(3) == 0) rx_req();
    end
    while (req_count < 800) random_sequence();

    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fails == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* accel_sensor_spi_register_file.f */
+incdir+src
src/acs_pkg.sv
src/acs_regmem.sv
src/accel_sensor_spi_register_file.sv
src/acs_checker.sv
tb/acs_checker.sv
tb/tb_top.sv
